@@ hdl/cbm_pkg.sv @@
// Shared types, codes and constants for the cartridge bank mapper.
`timescale 1ns / 1ps
package cbm_pkg;

    localparam int REG_COUNT = 16;
    localparam int REG_IDX_W = $clog2(REG_COUNT);

    // Bus access kinds
    localparam logic [1:0] CMD_CPU_RD = 2'd0;
    localparam logic [1:0] CMD_CPU_WR = 2'd1;
    localparam logic [1:0] CMD_PPU_RD = 2'd2;
    localparam logic [1:0] CMD_PPU_WR = 2'd3;

    // Result memory targets
    localparam logic [2:0] TGT_NONE    = 3'd0;
    localparam logic [2:0] TGT_PRG_ROM = 3'd1;
    localparam logic [2:0] TGT_PRG_RAM = 3'd2;
    localparam logic [2:0] TGT_CHR_ROM = 3'd3;
    localparam logic [2:0] TGT_CHR_RAM = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_PRG_MASK   = 2'd0;
    localparam logic [1:0] CFG_CHR_MASK   = 2'd1;
    localparam logic [1:0] CFG_CHR_IS_RAM = 2'd2;
    localparam logic [1:0] CFG_PRG_RAM    = 2'd3;

    // Parameter register roles
    localparam logic [REG_IDX_W-1:0] PREG_PRG_6000 = REG_IDX_W'(8);
    localparam logic [REG_IDX_W-1:0] PREG_PRG_8000 = REG_IDX_W'(9);
    localparam logic [REG_IDX_W-1:0] PREG_PRG_A000 = REG_IDX_W'(10);
    localparam logic [REG_IDX_W-1:0] PREG_PRG_C000 = REG_IDX_W'(11);
    localparam logic [REG_IDX_W-1:0] PREG_MIRROR   = REG_IDX_W'(12);
    localparam logic [REG_IDX_W-1:0] PREG_IRQ_CTRL = REG_IDX_W'(13);
    localparam logic [REG_IDX_W-1:0] PREG_IRQ_LO   = REG_IDX_W'(14);
    localparam logic [REG_IDX_W-1:0] PREG_IRQ_HI   = REG_IDX_W'(15);

    localparam logic [7:0] RST_PRG_MASK = 8'd15;
    localparam logic [7:0] RST_CHR_MASK = 8'd127;

    typedef logic [7:0] t_reg_file [REG_COUNT];

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] bus_address;
        logic [7:0]  write_data;
    } t_access;

    typedef struct packed {
        logic [7:0] prg_bank_mask;
        logic [7:0] chr_bank_mask;
        logic       chr_is_ram;
        logic       prg_ram_present;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mirroring;
        logic        irq_line;
        logic        memory_write;
        logic [20:0] memory_address;
        logic [2:0]  target;
    } t_result;

endpackage

@@ hdl/cbm_regs.sv @@
// Mapper state: command index, parameter registers and the IRQ down-counter.
`timescale 1ns / 1ps
module cbm_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  cbm_pkg::t_access i_access,
    output cbm_pkg::t_reg_file o_regs,
    output logic            o_irq_next,
    output logic [1:0]      o_mirror_next
);
    import cbm_pkg::*;

    logic [REG_IDX_W-1:0] r_cmd_index;
    t_reg_file            r_regs;
    logic [15:0]          r_irq_count;
    logic                 r_irq_pending;

    logic [REG_IDX_W-1:0] n_cmd_index;
    t_reg_file            n_regs;
    logic [15:0]          n_irq_count;
    logic                 n_irq_pending;

    logic        is_cpu;
    logic        is_cpu_wr;
    logic        tick;
    logic [15:0] cnt_dec;
    logic        sel_wr;
    logic        data_wr;

    always_comb begin
        is_cpu    = (i_access.command == CMD_CPU_RD) || (i_access.command == CMD_CPU_WR);
        is_cpu_wr = (i_access.command == CMD_CPU_WR);
        tick      = is_cpu && r_regs[PREG_IRQ_CTRL][7] && r_regs[PREG_IRQ_CTRL][0];
        cnt_dec   = r_irq_count - 16'd1;
        sel_wr    = is_cpu_wr && (i_access.bus_address[15:13] == 3'b100);
        data_wr   = is_cpu_wr && (i_access.bus_address >= 16'hA000);

        n_cmd_index   = r_cmd_index;
        n_regs        = r_regs;
        n_irq_count   = tick ? cnt_dec : r_irq_count;
        n_irq_pending = r_irq_pending | (tick && (r_irq_count == 16'd0));

        if (sel_wr) begin
            n_cmd_index = i_access.write_data[REG_IDX_W-1:0];
        end
        if (data_wr) begin
            n_regs[r_cmd_index] = i_access.write_data;
            case (r_cmd_index)
                PREG_IRQ_CTRL: n_irq_pending = 1'b0;
                PREG_IRQ_LO:   n_irq_count   = {n_irq_count[15:8], i_access.write_data};
                PREG_IRQ_HI:   n_irq_count   = {i_access.write_data, n_irq_count[7:0]};
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd_index   <= '0;
            r_irq_count   <= '0;
            r_irq_pending <= 1'b0;
            for (int k = 0; k < REG_COUNT; k++) begin
                r_regs[k] <= '0;
            end
        end else if (i_accept) begin
            r_cmd_index   <= n_cmd_index;
            r_regs        <= n_regs;
            r_irq_count   <= n_irq_count;
            r_irq_pending <= n_irq_pending;
        end
    end

    assign o_regs        = r_regs;
    assign o_irq_next    = n_irq_pending;
    assign o_mirror_next = n_regs[PREG_MIRROR][1:0] ^ 2'b01;

endmodule

@@ hdl/cbm_decode.sv @@
// Address decode: selects the target memory and forms the physical address.
`timescale 1ns / 1ps
module cbm_decode (
    input  cbm_pkg::t_access   i_access,
    input  cbm_pkg::t_reg_file i_regs,
    input  cbm_pkg::t_cfg      i_cfg,
    output logic [2:0]         o_target,
    output logic [20:0]        o_memory_address,
    output logic               o_memory_write
);
    import cbm_pkg::*;

    logic [7:0]  prg_bank;
    logic [7:0]  chr_bank;
    logic [20:0] prg_addr;
    logic [20:0] chr_addr;
    logic        ram_mapped;
    logic [15:0] addr;

    always_comb begin
        addr       = i_access.bus_address;
        ram_mapped = (i_regs[PREG_PRG_6000][7:6] == 2'b11);

        case (addr[15:13])
            3'b011:  prg_bank = {2'b00, i_regs[PREG_PRG_6000][5:0]};
            3'b100:  prg_bank = i_regs[PREG_PRG_8000];
            3'b101:  prg_bank = i_regs[PREG_PRG_A000];
            3'b110:  prg_bank = i_regs[PREG_PRG_C000];
            default: prg_bank = i_cfg.prg_bank_mask;
        endcase
        prg_addr = {(prg_bank & i_cfg.prg_bank_mask), addr[12:0]};

        chr_bank = i_regs[{1'b0, addr[12:10]}];
        chr_addr = {3'b000, (chr_bank & i_cfg.chr_bank_mask), addr[9:0]};

        o_target         = TGT_NONE;
        o_memory_address = '0;
        o_memory_write   = 1'b0;

        case (i_access.command)
            CMD_CPU_RD, CMD_CPU_WR: begin
                if (addr[15:13] == 3'b011) begin
                    if (ram_mapped) begin
                        if (i_cfg.prg_ram_present) begin
                            o_target         = TGT_PRG_RAM;
                            o_memory_address = {8'd0, addr[12:0]};
                            o_memory_write   = (i_access.command == CMD_CPU_WR);
                        end
                    end else if (i_access.command == CMD_CPU_RD) begin
                        o_target         = TGT_PRG_ROM;
                        o_memory_address = prg_addr;
                    end
                end else if (addr[15] && (i_access.command == CMD_CPU_RD)) begin
                    o_target         = TGT_PRG_ROM;
                    o_memory_address = prg_addr;
                end
            end
            CMD_PPU_RD: begin
                o_target         = i_cfg.chr_is_ram ? TGT_CHR_RAM : TGT_CHR_ROM;
                o_memory_address = chr_addr;
            end
            default: begin
                // writes land only in CHR RAM
                if (i_cfg.chr_is_ram) begin
                    o_target         = TGT_CHR_RAM;
                    o_memory_address = chr_addr;
                    o_memory_write   = 1'b1;
                end
            end
        endcase
    end

endmodule

@@ hdl/cartridge_bank_mapper_with_irq_unit.sv @@
// Top level of the cartridge bank mapper with an IRQ that counts CPU accesses.
`timescale 1ns / 1ps
// Usage:
//   Slave stream (i_s_*) carries one bus access per transaction: tuser holds
//   the access kind (CPU read/write, PPU read/write), tdata the bus address
//   and the write byte. Master stream (o_m_*) returns one result per access:
//   target memory, physical address, write strobe, IRQ line and mirroring.
//   Configuration (i_cfg_*) sets bank masks and memory presence; write it
//   only while no access is in flight. o_cfg_ready is always high.
// Throughput:
//   A taken access's result is registered. One access per cycle is sustained
//   while the master side takes results: decode and state update are a single
//   combinational pass from the accepted access to the output buffer.
//   A two-deep output buffer (result register plus skid register) lets an
//   access be taken while the previous result still waits; the slave side
//   stalls only when both are full.
// Reset:
//   Synchronous active-low reset clears the command index, all parameter
//   registers, the IRQ counter and pending flag, empties the output buffer
//   and restores the configuration defaults.
module cartridge_bank_mapper_with_irq_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [1:0]  i_s_tuser,   // [1:0] command
    input  logic [23:0] i_s_tdata,   // [15:0] bus_address, [23:16] write_data
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [2:0] target, [23:3] memory_address,
                                     // [24] memory_write, [25] irq_line,
                                     // [27:26] mirroring, [31:28] zero
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import cbm_pkg::*;

    t_access   acc;
    t_reg_file regs;
    t_cfg      r_cfg;
    t_result   res;
    t_result   r_out;
    t_result   r_skid;
    logic      r_out_valid;
    logic      r_skid_valid;
    logic      accept;
    logic      pop;
    logic      irq_next;
    logic [1:0] mirror_next;
    logic [2:0]  dec_target;
    logic [20:0] dec_addr;
    logic        dec_wr;

    assign acc.command     = i_s_tuser;
    assign acc.bus_address = i_s_tdata[15:0];
    assign acc.write_data  = i_s_tdata[23:16];

    assign o_s_tready  = !r_skid_valid;
    assign accept      = i_s_tvalid && o_s_tready;
    assign pop         = r_out_valid && i_m_tready;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prg_bank_mask   <= RST_PRG_MASK;
            r_cfg.chr_bank_mask   <= RST_CHR_MASK;
            r_cfg.chr_is_ram      <= 1'b0;
            r_cfg.prg_ram_present <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PRG_MASK:   r_cfg.prg_bank_mask   <= i_cfg_data;
                CFG_CHR_MASK:   r_cfg.chr_bank_mask   <= i_cfg_data;
                CFG_CHR_IS_RAM: r_cfg.chr_is_ram      <= i_cfg_data[0];
                CFG_PRG_RAM:    r_cfg.prg_ram_present <= i_cfg_data[0];
                default:        ;
            endcase
        end
    end

    cbm_regs u_regs (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_access      (acc),
        .o_regs        (regs),
        .o_irq_next    (irq_next),
        .o_mirror_next (mirror_next)
    );

    cbm_decode u_decode (
        .i_access         (acc),
        .i_regs           (regs),
        .i_cfg            (r_cfg),
        .o_target         (dec_target),
        .o_memory_address (dec_addr),
        .o_memory_write   (dec_wr)
    );

    always_comb begin
        res.target         = dec_target;
        res.memory_address = dec_addr;
        res.memory_write   = dec_wr;
        res.irq_line       = irq_next;
        res.mirroring      = mirror_next;
    end

    // Result register with skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            if (!r_out_valid || pop) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (!r_out_valid || pop) begin
                r_out <= res;
            end else begin
                r_skid <= res;
            end
        end else if (pop && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out};

endmodule

@@ tb/tb.sv @@
// Self-checking stream testbench for the cartridge bank mapper with IRQ counter.
`timescale 1ns / 1ps
module tb;
    import cbm_pkg::*;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic        o_s_tready;
    logic [1:0]  i_s_tuser   = '0;     // [1:0] command
    logic [23:0] i_s_tdata   = '0;     // [15:0] bus_address, [23:16] write_data
    logic        o_m_tvalid;
    logic        i_m_tready  = 1'b0;
    logic [31:0] o_m_tdata;            // [2:0] target, [23:3] memory_address,
                                       // [24] memory_write, [25] irq_line,
                                       // [27:26] mirroring, [31:28] zero
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data  = '0;

    cartridge_bank_mapper_with_irq_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tuser   (i_s_tuser),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Mapper state as the testbench sees it
    t_cfg        cfg_shadow = '{prg_bank_mask: RST_PRG_MASK, chr_bank_mask: RST_CHR_MASK,
                                chr_is_ram: 1'b0, prg_ram_present: 1'b1};
    t_reg_file   param_regs = '{default: '0};
    logic [3:0]  sel_index   = '0;
    logic [15:0] irq_count   = '0;
    logic        irq_pending = 1'b0;

    t_access pending_accesses [$];
    t_result expected_results [$];
    t_access cur_access;
    int      fail_count = 0;

    int burst_left = 1;
    int gap_left   = 0;
    bit drain_hold = 1'b0;
    int rx_mode    = 0;
    int rx_left    = 0;
    int rx_tick    = 0;

    // Decode one bus access and advance the mapper state
    function automatic t_result map_access(t_access acc);
        t_result     r;
        logic [7:0]  bank;
        logic [12:0] ppu_addr;
        r = '0;
        if (acc.command == CMD_CPU_RD || acc.command == CMD_CPU_WR) begin
            // counter ticks on every CPU access while enabled, before any decode
            if (param_regs[PREG_IRQ_CTRL][7] && param_regs[PREG_IRQ_CTRL][0]) begin
                irq_count = irq_count - 16'd1;
                if (irq_count == 16'hFFFF) irq_pending = 1'b1;
            end
            if (acc.bus_address < 16'h6000) begin
                r.target = TGT_NONE;
            end else if (acc.bus_address < 16'h8000) begin
                if (param_regs[PREG_PRG_6000][7:6] == 2'b11) begin
                    if (cfg_shadow.prg_ram_present) begin
                        r.target         = TGT_PRG_RAM;
                        r.memory_address = 21'(acc.bus_address - 16'h6000);
                        r.memory_write   = (acc.command == CMD_CPU_WR);
                    end
                end else if (acc.command == CMD_CPU_RD) begin
                    bank             = {2'b00, param_regs[PREG_PRG_6000][5:0]};
                    r.target         = TGT_PRG_ROM;
                    r.memory_address = {bank & cfg_shadow.prg_bank_mask,
                                        acc.bus_address[12:0]};
                end
            end else if (acc.command == CMD_CPU_WR) begin
                if (acc.bus_address < 16'hA000) begin
                    sel_index = acc.write_data[3:0];
                end else begin
                    param_regs[sel_index] = acc.write_data;
                    case (sel_index)
                        PREG_IRQ_CTRL: irq_pending = 1'b0;
                        PREG_IRQ_LO:   irq_count[7:0] = acc.write_data;
                        PREG_IRQ_HI:   irq_count[15:8] = acc.write_data;
                        default: ;
                    endcase
                end
            end else begin
                if (acc.bus_address < 16'hA000)      bank = param_regs[PREG_PRG_8000];
                else if (acc.bus_address < 16'hC000) bank = param_regs[PREG_PRG_A000];
                else if (acc.bus_address < 16'hE000) bank = param_regs[PREG_PRG_C000];
                else                                 bank = cfg_shadow.prg_bank_mask;
                r.target         = TGT_PRG_ROM;
                r.memory_address = {bank & cfg_shadow.prg_bank_mask, acc.bus_address[12:0]};
            end
        end else begin
            ppu_addr = acc.bus_address[12:0];
            bank     = param_regs[{1'b0, ppu_addr[12:10]}];
            if (acc.command == CMD_PPU_RD || cfg_shadow.chr_is_ram) begin
                r.target         = cfg_shadow.chr_is_ram ? TGT_CHR_RAM : TGT_CHR_ROM;
                r.memory_address = {3'b000, bank & cfg_shadow.chr_bank_mask, ppu_addr[9:0]};
                r.memory_write   = (acc.command == CMD_PPU_WR);
            end
        end
        r.irq_line  = irq_pending;
        r.mirroring = param_regs[PREG_MIRROR][1:0] ^ 2'b01;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        fail_count++;
        if (fail_count <= 25)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h at %0t ns", what, got, want,
                     $time);
    endtask

    function automatic void push_access(logic [1:0] cmd, logic [15:0] addr,
                                        logic [7:0] data);
        t_access a;
        a.command     = cmd;
        a.bus_address = addr;
        a.write_data  = data;
        pending_accesses.push_back(a);
    endfunction

    // Mostly register select/store pairs and mapped accesses, some noise
    task automatic queue_random_accesses(int count);
        int         left;
        int         pick;
        logic [3:0] idx;
        logic [7:0] val;
        logic [1:0] cmd;
        left = count;
        while (left > 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
                idx = 4'($urandom);
                case (idx)
                    PREG_IRQ_CTRL: val = $urandom_range(0, 1) ? 8'h81 : 8'($urandom);
                    PREG_IRQ_LO:   val = 8'($urandom_range(0, 24));
                    PREG_IRQ_HI:   val = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'h00;
                    PREG_PRG_6000: val = $urandom_range(0, 1) ? {2'b11, 6'($urandom)}
                                                              : 8'($urandom);
                    default:       val = 8'($urandom);
                endcase
                push_access(CMD_CPU_WR, 16'h8000 + 16'($urandom_range(0, 16'h1FFF)),
                            {4'($urandom), idx});
                push_access(CMD_CPU_WR, 16'($urandom_range(16'hA000, 16'hFFFF)), val);
                left -= 2;
            end else if (pick < 60) begin
                cmd = ($urandom_range(0, 3) == 0) ? CMD_CPU_WR : CMD_CPU_RD;
                push_access(cmd, 16'($urandom_range(16'h6000, 16'hFFFF)), 8'($urandom));
                left--;
            end else if (pick < 85) begin
                cmd = $urandom_range(0, 1) ? CMD_PPU_WR : CMD_PPU_RD;
                push_access(cmd, ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                 : 16'($urandom_range(0, 16'h1FFF)), 8'($urandom));
                left--;
            end else begin
                push_access(2'($urandom), 16'($urandom), 8'($urandom));
                left--;
            end
        end
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [7:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_PRG_MASK:   cfg_shadow.prg_bank_mask   = val;
            CFG_CHR_MASK:   cfg_shadow.chr_bank_mask   = val;
            CFG_CHR_IS_RAM: cfg_shadow.chr_is_ram      = val[0];
            CFG_PRG_RAM:    cfg_shadow.prg_ram_present = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [7:0] prg_mask, logic [7:0] chr_mask, logic chr_ram,
                              logic ram_present);
        write_cfg(CFG_PRG_MASK, prg_mask);
        write_cfg(CFG_CHR_MASK, chr_mask);
        write_cfg(CFG_CHR_IS_RAM, {7'($urandom), chr_ram});
        write_cfg(CFG_PRG_RAM, {7'($urandom), ram_present});
    endtask

    function automatic logic [7:0] random_mask();
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        return 8'((1 << $urandom_range(0, 8)) - 1);
    endfunction

    // Sample on the falling edge so the sender and receiver have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_accesses.size() != 0 || i_s_tvalid || expected_results.size() != 0);
    endtask

    // Sender: bursts of random length, random gaps, occasional hold until drained
    always @(posedge i_clk) begin
        logic nxt_valid;
        nxt_valid = i_s_tvalid && !o_s_tready;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                expected_results.push_back(map_access(cur_access));
            if (!i_s_tvalid || o_s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (drain_hold && expected_results.size() != 0) begin
                    nxt_valid = 1'b0;
                end else if (pending_accesses.size() != 0) begin
                    drain_hold = 1'b0;
                    cur_access = pending_accesses.pop_front();
                    i_s_tuser <= cur_access.command;
                    i_s_tdata <= {cur_access.write_data, cur_access.bus_address};
                    nxt_valid = 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                        drain_hold = ($urandom_range(0, 15) == 0);
                    end
                end
            end
        end
        i_s_tvalid <= nxt_valid;
    end

    // Receiver: check each result transaction, then pick the next ready value
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        logic    rdy;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = t_result'(o_m_tdata[27:0]);
            if (expected_results.size() == 0) begin
                report_mismatch("result with nothing expected", o_m_tdata, 0);
            end else begin
                want = expected_results.pop_front();
                if (got.target != want.target)
                    report_mismatch("target", got.target, want.target);
                if (got.memory_address != want.memory_address)
                    report_mismatch("memory_address", got.memory_address, want.memory_address);
                if (got.memory_write != want.memory_write)
                    report_mismatch("memory_write", got.memory_write, want.memory_write);
                if (got.irq_line != want.irq_line)
                    report_mismatch("irq_line", got.irq_line, want.irq_line);
                if (got.mirroring != want.mirroring)
                    report_mismatch("mirroring", got.mirroring, want.mirroring);
                if (o_m_tdata[31:28] != 4'd0)
                    report_mismatch("tdata padding", o_m_tdata[31:28], 0);
            end
        end
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_left = $urandom_range(10, 80);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_mode)
            0:       rdy = 1'b1;
            1:       rdy = 1'($urandom_range(0, 1));
            2:       rdy = ($urandom_range(0, 3) == 0);
            default: rdy = (rx_tick % 3 != 0);
        endcase
        i_m_tready <= rdy;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed accesses under the reset configuration
        push_access(CMD_CPU_RD, 16'h0000, 8'h00);   // below $6000: nothing
        push_access(CMD_CPU_RD, 16'hFFFF, 8'hFF);   // fixed last bank
        push_access(CMD_CPU_RD, 16'h8000, 8'h00);
        push_access(CMD_PPU_RD, 16'h0000, 8'h00);
        push_access(CMD_PPU_RD, 16'hFFFF, 8'h00);   // only low 13 bits decoded
        push_access(CMD_PPU_WR, 16'h0400, 8'hFF);   // CHR ROM: write dropped
        push_access(CMD_CPU_WR, 16'h6000, 8'hAA);   // ROM at $6000: write dropped
        push_access(CMD_CPU_RD, 16'h7FFF, 8'h00);
        push_access(CMD_CPU_WR, 16'h8000, 8'hF8);   // select register 8
        push_access(CMD_CPU_WR, 16'hA000, 8'hC0);   // map RAM at $6000
        push_access(CMD_CPU_RD, 16'h6000, 8'h00);
        push_access(CMD_CPU_WR, 16'h7FFF, 8'h55);
        push_access(CMD_CPU_WR, 16'h9FFF, 8'h09);
        push_access(CMD_CPU_WR, 16'hFFFF, 8'hFF);   // bank beyond the mask
        push_access(CMD_CPU_RD, 16'h9FFF, 8'h00);
        push_access(CMD_CPU_WR, 16'h8000, 8'h0C);
        push_access(CMD_CPU_WR, 16'hC000, 8'h03);   // mirroring
        push_access(CMD_CPU_WR, 16'h8000, 8'h0E);
        push_access(CMD_CPU_WR, 16'hA000, 8'h02);   // counter low byte
        push_access(CMD_CPU_WR, 16'h8000, 8'h0F);
        push_access(CMD_CPU_WR, 16'hA000, 8'h00);   // counter high byte
        push_access(CMD_CPU_WR, 16'h8000, 8'h0D);
        push_access(CMD_CPU_WR, 16'hA000, 8'h81);   // enable counting and IRQ
        push_access(CMD_CPU_RD, 16'h5FFF, 8'h00);
        push_access(CMD_CPU_RD, 16'h5FFF, 8'h00);
        push_access(CMD_CPU_RD, 16'hE000, 8'h00);   // counter wraps, IRQ pending
        push_access(CMD_PPU_RD, 16'h1FFF, 8'h00);   // PPU does not tick
        push_access(CMD_CPU_WR, 16'hA000, 8'h81);   // tick, then clear pending
        wait_idle();

        set_config(8'h00, 8'h00, 1'b1, 1'b0);
        queue_random_accesses(205);
        wait_idle();
        set_config(8'hFF, 8'hFF, 1'b0, 1'b1);
        queue_random_accesses(205);
        wait_idle();
        set_config(8'h3F, 8'h07, 1'b1, 1'b1);
        queue_random_accesses(205);
        wait_idle();
        set_config(8'h01, 8'hFF, 1'b0, 1'b0);
        queue_random_accesses(205);
        wait_idle();
        repeat (2) begin
            set_config(random_mask(), random_mask(), 1'($urandom), 1'($urandom));
            queue_random_accesses(205);
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("cartridge_bank_mapper_with_irq_unit test passed");
        end else begin
            $display("cartridge_bank_mapper_with_irq_unit test failed");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("cartridge_bank_mapper_with_irq_unit test failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/cbm_pkg.sv
hdl/cbm_regs.sv
hdl/cbm_decode.sv
hdl/cartridge_bank_mapper_with_irq_unit.sv
tb/tb.sv
